@@ hdl/sbo_pkg.sv @@
// Shared constants, codes and types for the segment/box overlap classifier.
// No dependencies; imported by sbo_cross_unit and the top level.
`default_nettype none
package sbo_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;              // Q format of coordinates, no effect on logic
    localparam int DIFF_W      = COORD_WIDTH + 1; // coordinate difference
    localparam int PROD_W      = 2 * DIFF_W;      // product of two differences
    localparam int CROSS_W     = PROD_W + 1;      // difference of two products
    localparam int LEVEL_W     = 6;
    localparam int CLASS_W     = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_PARTLY = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_FULL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SEG_START_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_START_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_END_X   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_END_Y   = 2'd3;

    // load enables of the arithmetic stages
    typedef struct packed {
        logic s2;
        logic s3;
    } t_stage_en;

endpackage
`default_nettype wire

@@ hdl/segment_box_overlap_classifier_unit.sv @@
// Top level of the segment/box overlap classifier: config registers, handshake
// and stage valids, endpoint tests and class select. Depends on sbo_pkg and sbo_cross_unit.
//
// Usage:
// - Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) loads the
//   segment endpoints: index 0 start x, 1 start y, 2 end x, 3 end y. Always ready.
//   Write only while no box is in flight.
// - Input channel (i_in_valid/o_in_ready) takes one box beat per cycle while
//   o_in_ready is high: bounds in signed Q16.16 and the tree level.
// - Output channel (o_out_valid/i_out_ready) returns one beat per box: the
//   overlap class (0 none, 1 partly, 2 fully within) and the level as score.
// - Four register stages: difference, multiply, cross-term subtract, compare
//   into the output register. The first loads at the accepting edge, and
//   o_out_valid rises once the box reaches the output register.
// - Takes one box per cycle unless stalled; the four stage registers carry valid bits.
// - A stalled receiver holds the output register; stages behind it keep
//   filling bubbles and then hold, so o_in_ready drops only when all are full.
// - Reset clears the stage valids and the endpoints to zero.
`default_nettype none
module segment_box_overlap_classifier_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [sbo_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [sbo_pkg::COORD_WIDTH-1:0]        i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [sbo_pkg::COORD_WIDTH-1:0] i_box_x_min,
    input  wire logic signed [sbo_pkg::COORD_WIDTH-1:0] i_box_x_max,
    input  wire logic signed [sbo_pkg::COORD_WIDTH-1:0] i_box_y_min,
    input  wire logic signed [sbo_pkg::COORD_WIDTH-1:0] i_box_y_max,
    input  wire logic [sbo_pkg::LEVEL_W-1:0]            i_tree_level,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [sbo_pkg::CLASS_W-1:0]                 o_overlap_class,
    output logic [sbo_pkg::LEVEL_W-1:0]                 o_node_score
);
    import sbo_pkg::*;

    logic signed [COORD_WIDTH-1:0] r_seg_start_x, r_seg_start_y, r_seg_end_x, r_seg_end_y;

    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic en1, en4;
    t_stage_en en_mid;

    // stage 1 to 3 payload
    logic signed [DIFF_W-1:0] r_s1_seg_dx, r_s1_seg_dy, r_s1_dx, r_s1_dy_lo, r_s1_dy_hi;
    logic signed [DIFF_W-1:0] r_s1_cx, r_s1_cy_lo, r_s1_cy_hi;
    logic                     r_s1_in_a, r_s1_in_b, r_s2_in_a, r_s2_in_b;
    logic                     r_s3_in_a, r_s3_in_b;
    logic [LEVEL_W-1:0]       r_s1_level, r_s2_level, r_s3_level;

    logic n_in_a, n_in_b;
    logic hit_lo, hit_hi;
    logic [CLASS_W-1:0]       n_class, r_class;
    logic [LEVEL_W-1:0]       r_score;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_start_x <= '0;
            r_seg_start_y <= '0;
            r_seg_end_x   <= '0;
            r_seg_end_y   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SEG_START_X: r_seg_start_x <= i_cfg_data;
                REG_SEG_START_Y: r_seg_start_y <= i_cfg_data;
                REG_SEG_END_X:   r_seg_end_x   <= i_cfg_data;
                REG_SEG_END_Y:   r_seg_end_y   <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // a stage loads when it is empty or the one ahead of it moves
    assign en4       = !r_s4_v || i_out_ready;
    assign en_mid.s3 = !r_s3_v || en4;
    assign en_mid.s2 = !r_s2_v || en_mid.s3;
    assign en1       = !r_s1_v || en_mid.s2;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (en1)       r_s1_v <= i_in_valid;
            if (en_mid.s2) r_s2_v <= r_s1_v;
            if (en_mid.s3) r_s3_v <= r_s2_v;
            if (en4)       r_s4_v <= r_s3_v;
        end
    end

    assign n_in_a = (r_seg_start_x >= i_box_x_min) && (r_seg_start_x <= i_box_x_max) &&
                    (r_seg_start_y >= i_box_y_min) && (r_seg_start_y <= i_box_y_max);
    assign n_in_b = (r_seg_end_x >= i_box_x_min) && (r_seg_end_x <= i_box_x_max) &&
                    (r_seg_end_y >= i_box_y_min) && (r_seg_end_y <= i_box_y_max);

    // lower diagonal runs (x_min,y_min)-(x_max,y_max), upper one (x_min,y_max)-(x_max,y_min)
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_seg_dx <= DIFF_W'(r_seg_end_x) - DIFF_W'(r_seg_start_x);
            r_s1_seg_dy <= DIFF_W'(r_seg_end_y) - DIFF_W'(r_seg_start_y);
            r_s1_dx     <= DIFF_W'(i_box_x_max) - DIFF_W'(i_box_x_min);
            r_s1_dy_lo  <= DIFF_W'(i_box_y_max) - DIFF_W'(i_box_y_min);
            r_s1_dy_hi  <= DIFF_W'(i_box_y_min) - DIFF_W'(i_box_y_max);
            r_s1_cx     <= DIFF_W'(i_box_x_min) - DIFF_W'(r_seg_start_x);
            r_s1_cy_lo  <= DIFF_W'(i_box_y_min) - DIFF_W'(r_seg_start_y);
            r_s1_cy_hi  <= DIFF_W'(i_box_y_max) - DIFF_W'(r_seg_start_y);
            r_s1_in_a   <= n_in_a;
            r_s1_in_b   <= n_in_b;
            r_s1_level  <= i_tree_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_mid.s2) begin
            r_s2_in_a  <= r_s1_in_a;
            r_s2_in_b  <= r_s1_in_b;
            r_s2_level <= r_s1_level;
        end
        if (en_mid.s3) begin
            r_s3_in_a  <= r_s2_in_a;
            r_s3_in_b  <= r_s2_in_b;
            r_s3_level <= r_s2_level;
        end
    end

    sbo_cross_unit u_cross_lo (
        .i_clk     (i_clk),
        .i_en      (en_mid),
        .i_seg_dx  (r_s1_seg_dx),
        .i_seg_dy  (r_s1_seg_dy),
        .i_diag_dx (r_s1_dx),
        .i_diag_dy (r_s1_dy_lo),
        .i_ofs_x   (r_s1_cx),
        .i_ofs_y   (r_s1_cy_lo),
        .o_hit     (hit_lo)
    );

    sbo_cross_unit u_cross_hi (
        .i_clk     (i_clk),
        .i_en      (en_mid),
        .i_seg_dx  (r_s1_seg_dx),
        .i_seg_dy  (r_s1_seg_dy),
        .i_diag_dx (r_s1_dx),
        .i_diag_dy (r_s1_dy_hi),
        .i_ofs_x   (r_s1_cx),
        .i_ofs_y   (r_s1_cy_hi),
        .o_hit     (hit_hi)
    );

    always_comb begin
        priority if (r_s3_in_a && r_s3_in_b) begin
            n_class = CLASS_FULL;
        end else if (r_s3_in_a || r_s3_in_b || hit_lo || hit_hi) begin
            n_class = CLASS_PARTLY;
        end else begin
            n_class = CLASS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_class <= n_class;
            r_score <= r_s3_level;
        end
    end

    assign o_out_valid     = r_s4_v;
    assign o_overlap_class = r_class;
    assign o_node_score    = r_score;

endmodule
`default_nettype wire

@@ hdl/sbo_cross_unit.sv @@
// Segment versus one box diagonal crossing test, two register stages deep.
// Depends on sbo_pkg; instantiated twice by the top level.
`default_nettype none
module sbo_cross_unit (
    input  wire logic                             i_clk,
    input  wire sbo_pkg::t_stage_en               i_en,
    input  wire logic signed [sbo_pkg::DIFF_W-1:0] i_seg_dx,
    input  wire logic signed [sbo_pkg::DIFF_W-1:0] i_seg_dy,
    input  wire logic signed [sbo_pkg::DIFF_W-1:0] i_diag_dx,
    input  wire logic signed [sbo_pkg::DIFF_W-1:0] i_diag_dy,
    input  wire logic signed [sbo_pkg::DIFF_W-1:0] i_ofs_x,
    input  wire logic signed [sbo_pkg::DIFF_W-1:0] i_ofs_y,
    output logic                                  o_hit
);
    import sbo_pkg::*;

    logic signed [PROD_W-1:0] r_p_den_a, r_p_den_b;
    logic signed [PROD_W-1:0] r_p_tn_a, r_p_tn_b;
    logic signed [PROD_W-1:0] r_p_un_a, r_p_un_b;
    logic signed [CROSS_W-1:0] r_den, r_tn, r_un;
    logic den_pos, den_zero, tn_ok, un_ok;

    // products of the three cross terms
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_p_den_a <= PROD_W'(i_seg_dx) * PROD_W'(i_diag_dy);
            r_p_den_b <= PROD_W'(i_seg_dy) * PROD_W'(i_diag_dx);
            r_p_tn_a  <= PROD_W'(i_ofs_x)  * PROD_W'(i_diag_dy);
            r_p_tn_b  <= PROD_W'(i_ofs_y)  * PROD_W'(i_diag_dx);
            r_p_un_a  <= PROD_W'(i_ofs_x)  * PROD_W'(i_seg_dy);
            r_p_un_b  <= PROD_W'(i_ofs_y)  * PROD_W'(i_seg_dx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_den <= CROSS_W'(r_p_den_a) - CROSS_W'(r_p_den_b);
            r_tn  <= CROSS_W'(r_p_tn_a)  - CROSS_W'(r_p_tn_b);
            r_un  <= CROSS_W'(r_p_un_a)  - CROSS_W'(r_p_un_b);
        end
    end

    // both ratios in [0,1] by sign and magnitude; parallel lines never hit
    assign den_zero = (r_den == '0);
    assign den_pos  = !r_den[CROSS_W-1] && !den_zero;
    assign tn_ok    = den_pos ? (!r_tn[CROSS_W-1] && (r_tn <= r_den))
                              : ((r_tn <= 0) && (r_tn >= r_den));
    assign un_ok    = den_pos ? (!r_un[CROSS_W-1] && (r_un <= r_den))
                              : ((r_un <= 0) && (r_un >= r_den));
    assign o_hit    = !den_zero && tn_ok && un_ok;

endmodule
`default_nettype wire
